// ===== design/lnrvs_pkg.sv =====
// ----------------------------------------------------------------------------
// lnrvs_pkg
// Shared types and constants of the lattice node velocity statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package lnrvs_pkg;

    localparam int DIRECTION_COUNT = 27;
    localparam int ACC_W           = 40;
    localparam int NODE_W          = 12;
    localparam int VAL_W           = 32;
    localparam int DIR_W           = 5;
    localparam int S_TDATA_W       = 88;
    localparam int M_TDATA_W       = 144;
    localparam int QUEUE_DEPTH     = 2;
    localparam int DIV_STEPS       = 64;

    // Per-axis sign codes of a lattice direction.
    localparam logic [1:0] SIGN_ZERO  = 2'b00;
    localparam logic [1:0] SIGN_PLUS  = 2'b01;
    localparam logic [1:0] SIGN_MINUS = 2'b10;

    // Packed as {z, y, x}, two bits per axis.
    typedef logic [5:0] axis_signs_t;

    localparam axis_signs_t DIR_SIGNS [DIRECTION_COUNT] = '{
        {SIGN_ZERO,  SIGN_ZERO,  SIGN_ZERO},
        {SIGN_ZERO,  SIGN_ZERO,  SIGN_PLUS},
        {SIGN_ZERO,  SIGN_ZERO,  SIGN_MINUS},
        {SIGN_ZERO,  SIGN_PLUS,  SIGN_ZERO},
        {SIGN_ZERO,  SIGN_MINUS, SIGN_ZERO},
        {SIGN_PLUS,  SIGN_ZERO,  SIGN_ZERO},
        {SIGN_MINUS, SIGN_ZERO,  SIGN_ZERO},
        {SIGN_ZERO,  SIGN_PLUS,  SIGN_PLUS},
        {SIGN_ZERO,  SIGN_MINUS, SIGN_MINUS},
        {SIGN_ZERO,  SIGN_MINUS, SIGN_PLUS},
        {SIGN_ZERO,  SIGN_PLUS,  SIGN_MINUS},
        {SIGN_PLUS,  SIGN_ZERO,  SIGN_PLUS},
        {SIGN_MINUS, SIGN_ZERO,  SIGN_MINUS},
        {SIGN_MINUS, SIGN_ZERO,  SIGN_PLUS},
        {SIGN_PLUS,  SIGN_ZERO,  SIGN_MINUS},
        {SIGN_PLUS,  SIGN_PLUS,  SIGN_ZERO},
        {SIGN_MINUS, SIGN_MINUS, SIGN_ZERO},
        {SIGN_MINUS, SIGN_PLUS,  SIGN_ZERO},
        {SIGN_PLUS,  SIGN_MINUS, SIGN_ZERO},
        {SIGN_PLUS,  SIGN_PLUS,  SIGN_PLUS},
        {SIGN_PLUS,  SIGN_MINUS, SIGN_MINUS},
        {SIGN_PLUS,  SIGN_MINUS, SIGN_PLUS},
        {SIGN_PLUS,  SIGN_PLUS,  SIGN_MINUS},
        {SIGN_MINUS, SIGN_PLUS,  SIGN_PLUS},
        {SIGN_MINUS, SIGN_MINUS, SIGN_MINUS},
        {SIGN_MINUS, SIGN_MINUS, SIGN_PLUS},
        {SIGN_MINUS, SIGN_PLUS,  SIGN_MINUS}
    };

    // Unknown directions contribute nothing.
    function automatic axis_signs_t dir_signs(input logic [DIR_W-1:0] dir);
        axis_signs_t s;
        s = '0;
        if (32'(dir) < DIRECTION_COUNT) begin
            s = DIR_SIGNS[dir];
        end
        return s;
    endfunction

    // One finished node velocity handed from the front end to the back end.
    typedef struct packed {
        logic [NODE_W-1:0]       node;
        logic [31:0]             t;
        logic signed [ACC_W-1:0] vx;
        logic signed [ACC_W-1:0] vy;
        logic signed [ACC_W-1:0] vz;
    } lnrvs_item_t;

endpackage

`default_nettype wire

// ===== design/lnrvs_ram.sv =====
// ----------------------------------------------------------------------------
// lnrvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lnrvs_ram #(
    parameter int WIDTH  = 128,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/lnrvs_front.sv =====
// ----------------------------------------------------------------------------
// lnrvs_front
// Accepts distributions and accumulates the three velocity moments of a node.
// ----------------------------------------------------------------------------
`default_nettype none

module lnrvs_front #(
    parameter int NODE_COUNT = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lnrvs_pkg::NODE_W-1:0]  node_index,
    input  wire logic [31:0]                   time_step,
    input  wire logic [lnrvs_pkg::DIR_W-1:0]   direction,
    input  wire logic [lnrvs_pkg::VAL_W-1:0]   dist_value,
    input  wire logic                          fluid,
    input  wire logic                          last,
    input  wire logic                          clear_busy,
    input  wire logic                          q_ready,
    output logic                               push_valid,
    output lnrvs_pkg::lnrvs_item_t             push_item
);
    import lnrvs_pkg::*;

    logic signed [ACC_W-1:0] sum_reg  [3];
    logic signed [ACC_W-1:0] sum_next [3];
    logic signed [ACC_W-1:0] added    [3];
    logic signed [ACC_W-1:0] ext;
    axis_signs_t             signs;
    logic                    accept;
    logic                    in_range;

    assign s_tready = q_ready && !clear_busy;
    assign accept   = s_tvalid && s_tready;
    assign ext      = {{(ACC_W-VAL_W){dist_value[VAL_W-1]}}, dist_value};
    assign signs    = fluid ? dir_signs(direction) : '0;
    assign in_range = {9'd0, node_index} < 21'(NODE_COUNT);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (signs[2*k +: 2] == SIGN_PLUS) begin
                added[k] = sum_reg[k] + ext;
            end else if (signs[2*k +: 2] == SIGN_MINUS) begin
                added[k] = sum_reg[k] - ext;
            end else begin
                added[k] = sum_reg[k];
            end
            sum_next[k] = sum_reg[k];
            if (accept) begin
                sum_next[k] = last ? '0 : added[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                sum_reg[k] <= '0;
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                sum_reg[k] <= sum_next[k];
            end
        end
    end

    assign push_valid     = accept && last && fluid && in_range;
    assign push_item.node = node_index;
    assign push_item.t    = time_step;
    assign push_item.vx   = added[0];
    assign push_item.vy   = added[1];
    assign push_item.vz   = added[2];

endmodule

`default_nettype wire

// ===== design/lnrvs_queue.sv =====
// ----------------------------------------------------------------------------
// lnrvs_queue
// Short register queue of finished node velocities between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lnrvs_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push_valid,
    output logic                        push_ready,
    input  wire lnrvs_pkg::lnrvs_item_t push_item,
    output logic                        pop_valid,
    input  wire logic                   pop_ready,
    output lnrvs_pkg::lnrvs_item_t      pop_item
);
    import lnrvs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lnrvs_item_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/lnrvs_back.sv =====
// ----------------------------------------------------------------------------
// lnrvs_back
// Sequencer that updates the stored mean and energy of one node at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lnrvs_back #(
    parameter int NODE_COUNT = 4096
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  wire lnrvs_pkg::lnrvs_item_t         pop_item,
    output logic                                clear_busy,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [lnrvs_pkg::M_TDATA_W-1:0]     m_tdata
);
    import lnrvs_pkg::*;

    localparam int AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int NW    = (AW > NODE_W) ? AW : NODE_W;
    localparam int CNT_W = $clog2(DIV_STEPS + 1);
    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef enum logic [16:0] {
        ST_CLEAR = 17'h00001,
        ST_IDLE  = 17'h00002,
        ST_READ  = 17'h00004,
        ST_MMUL  = 17'h00008,
        ST_MSIGN = 17'h00010,
        ST_MDIV  = 17'h00020,
        ST_MSAT  = 17'h00040,
        ST_DSUB  = 17'h00080,
        ST_SQHH  = 17'h00100,
        ST_SQHL  = 17'h00200,
        ST_SQLL  = 17'h00400,
        ST_SQACC = 17'h00800,
        ST_EMUL  = 17'h01000,
        ST_EADD  = 17'h02000,
        ST_EDIV  = 17'h04000,
        ST_ESAT  = 17'h08000,
        ST_WRITE = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]       axis_reg;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [AW-1:0]    clr_cnt_reg;
    logic             m_tvalid_reg;

    logic [NODE_W-1:0]       node_reg;
    logic [31:0]             t_reg;
    logic [32:0]             dvs_reg;
    logic signed [ACC_W-1:0] v_reg    [3];
    logic [31:0]             mean_reg [3];
    logic [31:0]             mres_reg [3];
    logic [31:0]             energy_reg;
    logic [31:0]             eres_reg;
    logic [63:0]             prod_reg;
    logic [63:0]             div_quo_reg;
    logic [32:0]             div_rem_reg;
    logic                    neg_reg;
    logic [39:0]             dmag_reg;
    logic [63:0]             sq_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic [31:0]  mul_a, mul_b;
    logic [31:0]  mean_mag;
    logic [39:0]  v_mag;
    logic [63:0]  mb;
    logic [63:0]  mag;
    logic         neg;
    logic [33:0]  rem_sh;
    logic [34:0]  diff;
    logic         ge;
    logic [31:0]  mean_sat;
    logic signed [40:0] dev;
    logic [39:0]  dev_mag;
    logic [64:0]  esum;
    logic         out_free;
    logic         ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [127:0] ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [127:0] ram_rdata;
    logic [NW-1:0]  node_ext_w;
    logic [NW-1:0]  node_ext_r;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign pop_ready  = state_reg == ST_IDLE;
    assign clear_busy = state_reg == ST_CLEAR;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    // Operand selection for the shared multiplier.
    assign mean_mag = mean_reg[axis_reg][31] ? 32'(-mean_reg[axis_reg])
                                             : mean_reg[axis_reg];
    assign v_mag    = v_reg[axis_reg][ACC_W-1] ? 40'(-v_reg[axis_reg])
                                               : 40'(v_reg[axis_reg]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MMUL: begin
                mul_a = mean_mag;
                mul_b = t_reg;
            end
            ST_SQHH: begin
                mul_a = 32'(dmag_reg[39:24]);
                mul_b = 32'(dmag_reg[39:24]);
            end
            ST_SQHL: begin
                mul_a = 32'(dmag_reg[39:24]);
                mul_b = 32'(dmag_reg[23:0]);
            end
            ST_SQLL: begin
                mul_a = 32'(dmag_reg[23:0]);
                mul_b = 32'(dmag_reg[23:0]);
            end
            ST_EMUL: begin
                mul_a = energy_reg;
                mul_b = t_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Signed-magnitude numerator of the mean update.
    always_comb begin
        mb = 64'(v_mag);
        if (mean_reg[axis_reg][31] == v_reg[axis_reg][ACC_W-1]) begin
            mag = prod_reg + mb;
            neg = mean_reg[axis_reg][31];
        end else if (prod_reg >= mb) begin
            mag = prod_reg - mb;
            neg = mean_reg[axis_reg][31];
        end else begin
            mag = mb - prod_reg;
            neg = v_reg[axis_reg][ACC_W-1];
        end
    end

    // One restoring division step per cycle.
    assign rem_sh = {div_rem_reg, div_quo_reg[63]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge     = !diff[34];

    always_comb begin
        if (!neg_reg) begin
            mean_sat = (|div_quo_reg[63:31]) ? 32'h7FFF_FFFF : div_quo_reg[31:0];
        end else if ((|div_quo_reg[63:32]) || (div_quo_reg[31] && (|div_quo_reg[30:0]))) begin
            mean_sat = 32'h8000_0000;
        end else begin
            mean_sat = 32'(-div_quo_reg[31:0]);
        end
    end

    assign dev     = {v_reg[axis_reg][ACC_W-1], v_reg[axis_reg]}
                   - {{9{mres_reg[axis_reg][31]}}, mres_reg[axis_reg]};
    assign dev_mag = dev[40] ? 40'(-dev) : dev[39:0];
    assign esum    = {1'b0, prod_reg} + {1'b0, sq_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == AW'(NODE_COUNT - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (pop_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_MMUL;
            ST_MMUL:  state_next = ST_MSIGN;
            ST_MSIGN: state_next = ST_MDIV;
            ST_MDIV:  if (div_cnt_reg == CNT_W'(1)) state_next = ST_MSAT;
            ST_MSAT:  state_next = (axis_reg == AXIS_LAST) ? ST_DSUB : ST_MMUL;
            ST_DSUB:  state_next = ST_SQHH;
            ST_SQHH:  state_next = ST_SQHL;
            ST_SQHL:  state_next = ST_SQLL;
            ST_SQLL:  state_next = ST_SQACC;
            ST_SQACC: state_next = (axis_reg == AXIS_LAST) ? ST_EMUL : ST_DSUB;
            ST_EMUL:  state_next = ST_EADD;
            ST_EADD:  state_next = esum[64] ? ST_WRITE : ST_EDIV;
            ST_EDIV:  if (div_cnt_reg == CNT_W'(1)) state_next = ST_ESAT;
            ST_ESAT:  state_next = ST_WRITE;
            ST_WRITE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            axis_reg     <= '0;
            div_cnt_reg  <= '0;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == ST_READ) begin
                axis_reg <= '0;
            end else if (state_reg == ST_MSAT || state_reg == ST_SQACC) begin
                axis_reg <= (axis_reg == AXIS_LAST) ? 2'd0 : axis_reg + 2'd1;
            end
            if (state_reg == ST_MSIGN || (state_reg == ST_EADD && !esum[64])) begin
                div_cnt_reg <= CNT_W'(DIV_STEPS);
            end else if (state_reg == ST_MDIV || state_reg == ST_EDIV) begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            if (state_reg == ST_WRITE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    node_reg <= pop_item.node;
                    t_reg    <= pop_item.t;
                    dvs_reg  <= {1'b0, pop_item.t} + 33'd1;
                    v_reg[0] <= pop_item.vx;
                    v_reg[1] <= pop_item.vy;
                    v_reg[2] <= pop_item.vz;
                end
            end
            ST_READ: begin
                mean_reg[0] <= ram_rdata[31:0];
                mean_reg[1] <= ram_rdata[63:32];
                mean_reg[2] <= ram_rdata[95:64];
                energy_reg  <= ram_rdata[127:96];
            end
            ST_MSIGN: begin
                div_quo_reg <= mag;
                div_rem_reg <= '0;
                neg_reg     <= neg;
            end
            ST_MDIV, ST_EDIV: begin
                div_rem_reg <= ge ? diff[32:0] : rem_sh[32:0];
                div_quo_reg <= {div_quo_reg[62:0], ge};
            end
            ST_MSAT: begin
                mres_reg[axis_reg] <= mean_sat;
                sq_reg             <= '0;
            end
            ST_DSUB: dmag_reg <= dev_mag;
            ST_SQHL: sq_reg <= sq_reg + (prod_reg << 24);
            ST_SQLL: sq_reg <= sq_reg + (prod_reg << 1);
            ST_SQACC: sq_reg <= sq_reg + (prod_reg >> 24);
            ST_EADD: begin
                if (esum[64]) begin
                    eres_reg <= 32'hFFFF_FFFF;
                end else begin
                    div_quo_reg <= esum[63:0];
                    div_rem_reg <= '0;
                end
            end
            ST_ESAT: begin
                eres_reg <= (|div_quo_reg[63:32]) ? 32'hFFFF_FFFF : div_quo_reg[31:0];
            end
            ST_WRITE: begin
                if (out_free) begin
                    m_tdata_reg <= {4'd0, eres_reg, mres_reg[2], mres_reg[1], mres_reg[0],
                                    node_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign node_ext_w = NW'(node_reg);
    assign node_ext_r = NW'(pop_item.node);
    assign ram_we     = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE && out_free);
    assign ram_waddr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : node_ext_w[AW-1:0];
    assign ram_wdata  = (state_reg == ST_CLEAR) ? '0
                      : {eres_reg, mres_reg[2], mres_reg[1], mres_reg[0]};
    assign ram_raddr  = node_ext_r[AW-1:0];

    lnrvs_ram #(
        .WIDTH (128),
        .DEPTH (NODE_COUNT)
    ) u_stats_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A finished node always leaves a result in the output register.
    a_write_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && out_free) |=> m_tvalid_reg)
        else $error("store write without a result");

    // The clearing pass runs once after reset only.
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("clearing pass re-entered");

    // The divider never runs out of steps while a division is in flight.
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MDIV || state_reg == ST_EDIV) |-> (div_cnt_reg != '0))
        else $error("division step count exhausted");

    // The axis counter stays on x, y or z.
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        axis_reg != 2'd3)
        else $error("axis counter out of range");

endmodule

`default_nettype wire

// ===== design/lattice_node_running_velocity_stats_top.sv =====
// A fluid node's result reaches the output register once the back end has updated its means
// and energy; when the energy numerator overflows, the energy division is skipped.
// Throughput: one distribution item per cycle while the node queue has room; the back end
// takes one fluid node at a time through its shared one-bit-per-cycle divider (64
// steps for each of three means and the energy). Non-fluid nodes cost the back end nothing.
// Reset: aresetn is synchronous and active low; afterwards a clearing pass zeroes every store
// entry (s_tready stays low) before the first item is taken.
// ----------------------------------------------------------------------------
// lattice_node_running_velocity_stats_top
// Running mean velocity and fluctuation energy per lattice node from D3Q27
// distributions.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_node_running_velocity_stats_top #(
    parameter int NODE_COUNT = 4096
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input item channel.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata from bit 0: node_index[12], time_step[32], direction[5], dist_value[32], zero fill.
    input  wire logic [lnrvs_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: fluid[1].
    input  wire logic                              s_tuser,
    input  wire logic                              s_tlast,
    // Result item channel.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tdata from bit 0: out_node[12], mean_vx[32], mean_vy[32], mean_vz[32],
    // fluct_energy[32], zero fill.
    output logic [lnrvs_pkg::M_TDATA_W-1:0]        m_tdata
);
    import lnrvs_pkg::*;

    // Front end to queue and queue to back end handshakes.
    logic        push_valid;
    logic        push_ready;
    lnrvs_item_t push_item;
    logic        pop_valid;
    logic        pop_ready;
    lnrvs_item_t pop_item;
    logic        clear_busy;

    // The front end accumulates the three velocity sums at one item per cycle while
    // s_tready is high. On the node's last item it hands the finished velocity to the
    // queue if the node is fluid and within the store; otherwise the sums are just cleared.
    lnrvs_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .node_index (s_tdata[11:0]),
        .time_step  (s_tdata[43:12]),
        .direction  (s_tdata[48:44]),
        .dist_value (s_tdata[80:49]),
        .fluid      (s_tuser),
        .last       (s_tlast),
        .clear_busy (clear_busy),
        .q_ready    (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    // The queue lets the front end keep streaming the next node while the back end
    // is still dividing.
    lnrvs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // The back end reads the node's stored means and energy, updates them with one
    // shared multiplier and one iterative divider, writes them back and presents the
    // result in an output register.
    lnrvs_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire
